FILE: rtl/srf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_pkg
// Register map, reset values and fixed widths of the spring force block.
// ----------------------------------------------------------------------------
package srf_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int STIFF_W    = 32;
    localparam int REST_W     = 31;

    typedef enum logic {
        REG_STIFFNESS   = 1'b0,
        REG_REST_LENGTH = 1'b1
    } t_reg_idx;

    localparam logic [STIFF_W-1:0] STIFFNESS_RESET   = 32'd65536;
    localparam logic [REST_W-1:0]  REST_LENGTH_RESET = 31'd65536;

endpackage

FILE: rtl/srf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_if
// Valid/ready channels for spring position items and force results.
// ----------------------------------------------------------------------------
interface srf_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic signed [W-1:0] first_z;
    logic signed [W-1:0] second_x;
    logic signed [W-1:0] second_y;
    logic signed [W-1:0] second_z;
    logic                toward_second;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, toward_second, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, toward_second, output ready);
endinterface

interface srf_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] force_x;
    logic signed [W-1:0] force_y;
    logic signed [W-1:0] force_z;
    logic                zero_length;
    logic                saturated;

    modport source (output valid, force_x, force_y, force_z, zero_length, saturated,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, zero_length, saturated,
                    output ready);
endinterface

FILE: rtl/spring_restoring_force_3d.sv
`timescale 1ns / 1ps
// Pipeline depth from input transaction to result is set by one register per
//   square-root bit and per quotient bit.
// Throughput: one transaction per cycle while the skid is empty; a two-entry
//   output skid keeps input open while a result waits; input stalls when the skid is full.
// Reset: synchronous active low; clears all valid bits, stiffness and
//   rest_length return to 1.0.
// ----------------------------------------------------------------------------
// spring_restoring_force_3d
// Pipelined Hooke spring force: difference, squared length, bit-serial
// square root, unit vector division, scale by stiffness and stretch, saturate.
// ----------------------------------------------------------------------------
module spring_restoring_force_3d import srf_pkg::*; #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    srf_in_if.sink                i_in,
    srf_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int MW  = W + 1;
    localparam int LW  = W + 1;
    localparam int SW  = 2 * W + 2;
    localparam int EW  = (LW > REST_W) ? LW : REST_W;
    localparam int KW  = STIFF_W + EW;
    localparam int UW  = F + 1;
    localparam int PRW = KW + UW;
    localparam int PMW = PRW - 2 * F;
    localparam int RW  = LW + 1;

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic               flip;
        logic               zero;
    } t_side;

    typedef struct packed {
        logic [2:0][W-1:0] frc;
        logic              zl;
        logic              sat;
    } t_res;

    // ---------------- configuration ----------------
    logic [STIFF_W-1:0] r_stiff;
    logic [REST_W-1:0]  r_rest;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFFNESS_RESET;
            r_rest  <= REST_LENGTH_RESET;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[2]))
                REG_STIFFNESS:   r_stiff <= pwdata;
                REG_REST_LENGTH: r_rest  <= pwdata[REST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_STIFFNESS:   prdata = r_stiff;
            REG_REST_LENGTH: prdata = {1'b0, r_rest};
            default:         prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic en;
    logic take;
    logic r_skid_vld;
    logic r_out_vld;

    assign en          = !r_skid_vld;
    assign take        = r_out_vld && o_out.ready;
    assign i_in.ready  = en;

    // ---------------- stage 1: differences ----------------
    logic signed [MW-1:0] w_d [3];
    t_side                w_s1;

    assign w_d[0] = {i_in.first_x[W-1], i_in.first_x} - {i_in.second_x[W-1], i_in.second_x};
    assign w_d[1] = {i_in.first_y[W-1], i_in.first_y} - {i_in.second_y[W-1], i_in.second_y};
    assign w_d[2] = {i_in.first_z[W-1], i_in.first_z} - {i_in.second_z[W-1], i_in.second_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s1.neg[i] = w_d[i][MW-1];
            w_s1.mag[i] = w_d[i][MW-1] ? -w_d[i] : w_d[i];
        end
        w_s1.flip = i_in.toward_second;
        w_s1.zero = (w_d[0] == '0) && (w_d[1] == '0) && (w_d[2] == '0);
    end

    t_side r_s1_side;
    logic  r_s1_vld;
    t_side r_s2_side;
    logic  r_s2_vld;
    logic [SW-1:0] r_s2_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in.valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= w_s1;
            r_s2_side <= r_s1_side;
            for (int i = 0; i < 3; i++) begin
                r_s2_sq[i] <= SW'(r_s1_side.mag[i]) * SW'(r_s1_side.mag[i]);
            end
        end
    end

    // ---------------- square root, one bit per stage ----------------
    t_side          r_qs_side [0:LW];
    logic [SW-1:0]  r_qs_rem  [0:LW];
    logic [LW-1:0]  r_qs_root [0:LW];
    logic           r_qs_vld  [0:LW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qs_vld[0] <= 1'b0;
        end else if (en) begin
            r_qs_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qs_side[0] <= r_s2_side;
            r_qs_rem[0]  <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_qs_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        localparam int B = LW - 1 - k;
        logic [SW-1:0] w_t;
        logic          w_ge;

        assign w_t  = (SW'(r_qs_root[k]) << (B + 1)) + (SW'(1) << (2 * B));
        assign w_ge = r_qs_rem[k] >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qs_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_qs_vld[k+1] <= r_qs_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qs_side[k+1] <= r_qs_side[k];
                r_qs_rem[k+1]  <= w_ge ? r_qs_rem[k] - w_t : r_qs_rem[k];
                r_qs_root[k+1] <= w_ge ? (r_qs_root[k] | (LW'(1) << B)) : r_qs_root[k];
            end
        end
    end

    // ---------------- stretch ----------------
    logic [EW-1:0] w_len_e;
    logic [EW-1:0] w_rest_e;

    assign w_len_e  = EW'(r_qs_root[LW]);
    assign w_rest_e = EW'(r_rest);

    t_side         r_e_side;
    logic [LW-1:0] r_e_len;
    logic [EW-1:0] r_e_emag;
    logic          r_e_eneg;
    logic          r_e_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_qs_vld[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side <= r_qs_side[LW];
            r_e_len  <= r_qs_root[LW];
            r_e_eneg <= w_len_e < w_rest_e;
            r_e_emag <= (w_len_e < w_rest_e) ? w_rest_e - w_len_e : w_len_e - w_rest_e;
        end
    end

    // ---------------- unit vector, one quotient bit per stage ----------------
    t_side         r_dv_side [0:F];
    logic [LW-1:0] r_dv_len  [0:F];
    logic          r_dv_eneg [0:F];
    logic [KW-1:0] r_dv_ke   [0:F];
    logic [RW-1:0] r_dv_rem  [0:F][3];
    logic [UW-1:0] r_dv_q    [0:F][3];
    logic          r_dv_vld  [0:F];

    for (genvar j = 0; j <= F; j++) begin : g_div
        t_side         w_side;
        logic [LW-1:0] w_len;
        logic          w_eneg;
        logic [KW-1:0] w_ke;
        logic          w_vld;
        logic [RW-1:0] w_r  [3];
        logic [UW-1:0] w_qi [3];

        if (j == 0) begin : g_first
            assign w_side = r_e_side;
            assign w_len  = r_e_len;
            assign w_eneg = r_e_eneg;
            assign w_ke   = KW'(r_stiff) * KW'(r_e_emag);
            assign w_vld  = r_e_vld;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign w_r[i]  = RW'(r_e_side.mag[i]);
                assign w_qi[i] = '0;
            end
        end else begin : g_next
            assign w_side = r_dv_side[j-1];
            assign w_len  = r_dv_len[j-1];
            assign w_eneg = r_dv_eneg[j-1];
            assign w_ke   = r_dv_ke[j-1];
            assign w_vld  = r_dv_vld[j-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign w_r[i]  = r_dv_rem[j-1][i] << 1;
                assign w_qi[i] = r_dv_q[j-1][i] << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[j] <= w_side;
                r_dv_len[j]  <= w_len;
                r_dv_eneg[j] <= w_eneg;
                r_dv_ke[j]   <= w_ke;
                for (int i = 0; i < 3; i++) begin
                    if (w_r[i] >= RW'(w_len)) begin
                        r_dv_rem[j][i] <= w_r[i] - RW'(w_len);
                        r_dv_q[j][i]   <= w_qi[i] | UW'(1);
                    end else begin
                        r_dv_rem[j][i] <= w_r[i];
                        r_dv_q[j][i]   <= w_qi[i];
                    end
                end
            end
        end
    end

    // ---------------- scale ----------------
    t_side          r_m_side;
    logic           r_m_eneg;
    logic [PRW-1:0] r_m_prod [3];
    logic           r_m_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_dv_vld[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_side <= r_dv_side[F];
            r_m_eneg <= r_dv_eneg[F];
            for (int i = 0; i < 3; i++) begin
                r_m_prod[i] <= PRW'(r_dv_ke[F]) * PRW'(r_dv_q[F][i]);
            end
        end
    end

    // ---------------- saturate ----------------
    t_res w_res;

    always_comb begin
        logic [PMW-1:0] pmag;
        logic [PMW-1:0] limit;
        logic [PMW-1:0] v;
        logic           fneg;
        w_res.sat = 1'b0;
        w_res.zl  = r_m_side.zero;
        for (int i = 0; i < 3; i++) begin
            pmag  = r_m_prod[i][PRW-1:2*F];
            fneg  = (r_m_eneg == r_m_side.neg[i]) ^ r_m_side.flip;
            limit = fneg ? (PMW'(1) << (W - 1)) : ((PMW'(1) << (W - 1)) - PMW'(1));
            v     = pmag;
            if (pmag > limit) begin
                v = limit;
                if (!r_m_side.zero) begin
                    w_res.sat = 1'b1;
                end
            end
            if (r_m_side.zero) begin
                w_res.frc[i] = '0;
            end else begin
                w_res.frc[i] = fneg ? -v[W-1:0] : v[W-1:0];
            end
        end
    end

    t_res r_p_res;
    logic r_p_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_res <= w_res;
        end
    end

    // ---------------- output register and skid ----------------
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (r_p_vld) begin
            // park the result in the skid when the output is still held
            if (!r_out_vld || take) begin
                r_out     <= r_p_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= r_p_res;
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.force_x     = r_out.frc[0];
    assign o_out.force_y     = r_out.frc[1];
    assign o_out.force_z     = r_out.frc[2];
    assign o_out.zero_length = r_out.zl;
    assign o_out.saturated   = r_out.sat;

endmodule

FILE: rtl/srf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_checker
// Port-level checks on the spring force results.
// ----------------------------------------------------------------------------
module srf_checker #(
    parameter int W = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_fx,
    input logic [W-1:0] i_fy,
    input logic [W-1:0] i_fz,
    input logic         i_zl,
    input logic         i_sat
);

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_fx, i_fy, i_fz, i_zl, i_sat}))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zl |-> i_fx == '0 && i_fy == '0 && i_fz == '0 && !i_sat)
        else $error("zero-length spring with nonzero force");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> i_fx == MAX_POS || i_fx == MIN_NEG || i_fy == MAX_POS
            || i_fy == MIN_NEG || i_fz == MAX_POS || i_fz == MIN_NEG)
        else $error("saturation flag without a clipped component");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind spring_restoring_force_3d srf_checker #(.W(COORD_WIDTH)) u_srf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_fx        (o_out.force_x),
    .i_fy        (o_out.force_y),
    .i_fz        (o_out.force_z),
    .i_zl        (o_out.zero_length),
    .i_sat       (o_out.saturated)
);
